[design/command_token_lexer_core_defines.svh]
// Assertion macros used by the checker of the token lexer.
`ifndef COMMAND_TOKEN_LEXER_CORE_DEFINES_SVH
`define COMMAND_TOKEN_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet while in reset.
`define CTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet while in reset.
`define CTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ctl_pkg.sv]
// Package of the command token lexer: widths, codes, result types and byte classes.
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int KIND_W      = 2;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 40;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef logic [OFFSET_BITS-1:0] t_cnt;
    typedef logic [KIND_W-1:0]      t_kind;

    localparam t_kind KIND_NUM = 2'd0;
    localparam t_kind KIND_SYM = 2'd1;
    localparam t_kind KIND_STR = 2'd2;
    localparam t_kind KIND_LF  = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One result word as it leaves the block.
    typedef struct packed {
        t_kind             kind;
        logic              space;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic              last;
    } t_tok;

    // Up to two words written into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_tok       w0;
        t_tok       w1;
    } t_push;

    function automatic logic is_num(input logic [7:0] ch);
        return ((ch >= CH_ZERO) && (ch <= CH_NINE)) || (ch == CH_DOT);
    endfunction

    // Single-byte symbols: , @ ~ ^ / $ & ' ! # % + * = [ { ] } \ | < > ` - :
    function automatic logic is_sym(input logic [7:0] ch);
        logic hit;
        hit = 1'b0;
        case (ch) inside
            8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h27, 8'h21,
            8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B, 8'h5D, 8'h7D,
            8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h2D, 8'h3A: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Bytes that end an unquoted string: space , @ ~ ^ / $ & " ' ! # % + * =
    // [ { ] } \ | < > ` and line feed.
    function automatic logic is_end(input logic [7:0] ch);
        logic hit;
        hit = 1'b0;
        case (ch) inside
            8'h20, 8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h22,
            8'h27, 8'h21, 8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B,
            8'h5D, 8'h7D, 8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h0A: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : t_cnt'(v + 1'b1);
    endfunction

    // Limit a counter to the largest value of a 16-bit field.
    function automatic logic [FIELD_W-1:0] clamp_field(input t_cnt v);
        logic [32:0] wide;
        wide = 33'(v);
        return (wide > 33'(16'hFFFF)) ? {FIELD_W{1'b1}} : FIELD_W'(v);
    endfunction

endpackage

[design/ctl_lex.sv]
// Lexer state registers and the per-byte step that produces up to two tokens.
`timescale 1ns / 1ps

module ctl_lex (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output ctl_pkg::t_push  o_push
);
    import ctl_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SIGN = 3'd1;
    localparam logic [2:0] MODE_NUM  = 3'd2;
    localparam logic [2:0] MODE_UNQ  = 3'd3;
    localparam logic [2:0] MODE_QUO  = 3'd4;

    logic [2:0] r_mode, n_mode;
    t_cnt       r_boff, n_boff;
    t_cnt       r_tstart, n_tstart;
    t_cnt       r_tlen, n_tlen;
    logic       r_sseen, n_sseen;
    logic       r_tsflag, n_tsflag;

    logic       c_num, c_end, c_sym;
    logic       cont, fresh;
    logic       emit_a, emit_b;
    t_kind      kind_a, kind_b;
    logic [2:0] mode1;
    t_cnt       start1, len1;
    logic       sseen1, flag1;
    t_tok       tok_a, tok_b;

    always_comb begin
        c_num = is_num(i_char);
        c_end = is_end(i_char);
        c_sym = is_sym(i_char);

        // First phase: does the open token continue, end, or is there none?
        cont   = 1'b0;
        fresh  = 1'b0;
        emit_a = 1'b0;
        kind_a = KIND_STR;
        unique case (r_mode)
            MODE_SIGN: begin
                cont   = c_num;
                emit_a = !c_num;
                kind_a = KIND_SYM;
            end
            MODE_NUM: begin
                cont   = c_num;
                emit_a = !c_num;
                kind_a = KIND_NUM;
            end
            MODE_UNQ: begin
                cont   = !c_end;
                emit_a = c_end;
                kind_a = KIND_STR;
            end
            MODE_QUO: begin
                cont   = 1'b1;
                emit_a = (i_char == CH_QUOTE);
                kind_a = KIND_STR;
            end
            default: begin
                cont = 1'b0;
            end
        endcase
        fresh = !cont;

        mode1  = r_mode;
        start1 = r_tstart;
        len1   = r_tlen;
        sseen1 = r_sseen;
        flag1  = r_tsflag;
        emit_b = 1'b0;
        kind_b = KIND_SYM;

        if (cont) begin
            len1 = sat_inc(r_tlen);
            if (r_mode == MODE_SIGN) begin
                mode1 = MODE_NUM;
            end else if ((r_mode == MODE_QUO) && (i_char == CH_QUOTE)) begin
                mode1 = MODE_IDLE;
            end
        end else if (fresh) begin
            mode1 = MODE_IDLE;
            if (i_char == CH_SPACE) begin
                sseen1 = 1'b1;
            end else begin
                flag1  = r_sseen;
                sseen1 = 1'b0;
                start1 = r_boff;
                len1   = t_cnt'(1);
                if (i_char == CH_LF) begin
                    emit_b = 1'b1;
                    kind_b = KIND_LF;
                end else if (c_num) begin
                    mode1 = MODE_NUM;
                end else if ((i_char == CH_PLUS) || (i_char == CH_MINUS)) begin
                    mode1 = MODE_SIGN;
                end else if (c_sym) begin
                    emit_b = 1'b1;
                    kind_b = KIND_SYM;
                end else if (i_char == CH_QUOTE) begin
                    mode1 = MODE_QUO;
                end else begin
                    mode1 = MODE_UNQ;
                end
            end
        end

        // End of text flushes whatever token is still open.
        if (i_last) begin
            unique case (mode1) inside
                MODE_SIGN: begin
                    emit_b = 1'b1;
                    kind_b = KIND_SYM;
                end
                MODE_NUM: begin
                    emit_b = 1'b1;
                    kind_b = KIND_NUM;
                end
                MODE_UNQ, MODE_QUO: begin
                    emit_b = 1'b1;
                    kind_b = KIND_STR;
                end
                default: begin
                    emit_b = emit_b;
                end
            endcase
        end

        tok_a.kind  = kind_a;
        tok_a.space = r_tsflag;
        tok_a.start = clamp_field(r_tstart);
        tok_a.len   = clamp_field(len1);
        tok_a.last  = !emit_b;
        // The ending token keeps its own length unless the quote closed it.
        if (r_mode != MODE_QUO) begin
            tok_a.len = clamp_field(r_tlen);
        end

        tok_b.kind  = kind_b;
        tok_b.space = flag1;
        tok_b.start = clamp_field(start1);
        tok_b.len   = clamp_field(len1);
        tok_b.last  = 1'b1;

        o_push.count = 2'(emit_a) + 2'(emit_b);
        o_push.w0    = emit_a ? tok_a : tok_b;
        o_push.w1    = tok_b;
        if (!i_advance) begin
            o_push.count = 2'd0;
        end

        if (i_last) begin
            n_mode   = MODE_IDLE;
            n_boff   = '0;
            n_tstart = '0;
            n_tlen   = '0;
            n_sseen  = 1'b0;
            n_tsflag = 1'b0;
        end else begin
            n_mode   = mode1;
            n_boff   = sat_inc(r_boff);
            n_tstart = start1;
            n_tlen   = len1;
            n_sseen  = sseen1;
            n_tsflag = flag1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_boff   <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_sseen  <= 1'b0;
            r_tsflag <= 1'b0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_boff   <= n_boff;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_sseen  <= n_sseen;
            r_tsflag <= n_tsflag;
        end
    end

endmodule

[design/ctl_outq.sv]
// Small output queue that takes up to two result words per cycle and gives one while the reader is ready.
`timescale 1ns / 1ps

module ctl_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctl_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output ctl_pkg::t_tok  o_word
);
    import ctl_pkg::*;

    t_tok                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, n_wp;
    logic [QPTR_W-1:0]   r_rp, n_rp;
    logic [QPTR_W:0]     r_count, n_count;
    logic                pop;
    logic [QPTR_W-1:0]   wp1;

    always_comb begin
        pop     = (r_count != '0) && i_ready;
        wp1     = r_wp + 1'b1;
        n_wp    = r_wp + QPTR_W'(i_push.count);
        n_rp    = pop ? QPTR_W'(r_rp + 1'b1) : r_rp;
        n_count = r_count + (QPTR_W + 1)'(i_push.count) - (QPTR_W + 1)'(pop);
        o_valid = (r_count != '0);
        o_room  = (r_count <= (QPTR_W + 1)'(QDEPTH - 2));
        o_word  = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.w0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.w1;
        end
    end

endmodule

[design/command_token_lexer_core.sv]
// Top level of the command token lexer: input register, lexer step and output queue.
`timescale 1ns / 1ps

// Command token lexer. Bytes of a command text arrive one per word on the slave
// stream, with tlast on the final byte of a text; tokens leave on the master
// stream, one token per word, with tlast set on the final token caused by a given
// byte. A token is a number (optional sign, then digits and dots), a one-byte
// symbol, a line feed, or a string (quoted, quotes included, or unquoted up to an
// end byte). Each token carries its kind, a flag for spaces before it, its start
// offset within the text and its length; offsets and lengths stop at 65535. A byte
// is taken every cycle while the queue has room: it waits in the input register,
// the lexer step updates the mode machine and writes zero, one or two tokens into
// a four-word queue, and the queue offers the first token from the edge that
// writes it. The master port drains one token per cycle while the receiver is
// ready, so a byte that both closes one token and produces another puts two words
// in the queue; a text whose bytes mostly do that runs at the output rate, one
// token per cycle, and the slave side stalls only when the queue holds more than
// two words. The end of a text returns all state to reset, so the next byte
// begins a new text at offset zero.

module command_token_lexer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream: tdata = char_byte[7:0]; tlast = end_of_text.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [ctl_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    // Master stream: tdata = space_before[0], start_offset[16:1],
    // token_length[32:17], zero fill [39:33]; tuser = token_kind[1:0];
    // tlast = last_of_run.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [ctl_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata,
    output logic [ctl_pkg::KIND_W-1:0]      o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import ctl_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       q_room;
    logic       advance;
    logic       take;
    t_push      push;
    t_tok       word;

    // The byte in the input register moves on whenever the queue can take two
    // words, which keeps the two handshakes free of any combinational path.
    assign advance         = r_in_valid && q_room;
    assign o_s_axis_tready = !r_in_valid || q_room;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    ctl_lex u_lex (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .o_push    (push)
    );

    ctl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_word  (word)
    );

    assign o_m_axis_tdata = {(TDATA_OUT_W - 2 * FIELD_W - 1)'(0), word.len, word.start,
                             word.space};
    assign o_m_axis_tuser = word.kind;
    assign o_m_axis_tlast = word.last;

endmodule

[design/ctl_chk.sv]
// Port-level checker of the token lexer and its bind to the top level.
`timescale 1ns / 1ps
`include "command_token_lexer_core_defines.svh"

module ctl_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [ctl_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ctl_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata,
    input logic [ctl_pkg::KIND_W-1:0]      o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);
    import ctl_pkg::*;

    // A word offered and not taken stays offered.
    `CTL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output word withdrawn while stalled")

    // Every token covers at least one byte.
    `CTL_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[32:17] != 16'd0, "token of zero length")

    // Symbols, pending signs included, and line feeds are single bytes.
    `CTL_ASSERT_NOW(a_single_byte, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == KIND_SYM || o_m_axis_tuser == KIND_LF), o_m_axis_tdata[32:17] == 16'd1, "symbol or line feed longer than one byte")

    // The fill bits above the length are always zero.
    `CTL_ASSERT_NOW(a_fill_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[39:33] == 7'd0, "nonzero fill bits in output word")

endmodule

bind command_token_lexer_core ctl_chk u_ctl_chk (.*);

[sim/tb_command_token_lexer_core.sv]
// Self-checking testbench of the command token lexer, with its own token predictor.
`timescale 1ns / 1ps

module tb_command_token_lexer_core;

    import ctl_pkg::*;

    // Byte classes of the lexer. The backtick is written as an octal escape.
    localparam string END_CHARS = " ,@~^/$&\"'!#%+*=[{]}\\|<>\140\n";
    localparam string SYM_CHARS = ",@~^/$&'!#%+*=[{]}\\|<>\140-:";
    localparam string NUM_CHARS = "0123456789.";

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam int RANDOM_BYTES  = 1425;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 30;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_SIGN,
        LX_NUMBER,
        LX_UNQUOTED,
        LX_QUOTED
    } t_lx_mode;

    typedef struct {
        t_kind       kind;
        logic        space;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_token;

    // One row of the directed table. A row with n_typed below zero is checked
    // against the predictor; otherwise its tokens are the ones typed in.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        int         n_typed;
        t_token     t0;
        t_token     t1;
    } t_stim_row;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [TDATA_IN_W-1:0]  s_data  = '0;
    logic                   s_last  = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;
    logic [KIND_W-1:0]      o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    command_token_lexer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),      // char_byte[7:0]
        .i_s_axis_tlast  (s_last),      // end_of_text
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // space[0], start[16:1], len[32:17], zero[39:33]
        .o_m_axis_tuser  (o_m_axis_tuser), // token_kind[1:0]
        .o_m_axis_tlast  (o_m_axis_tlast)  // last_of_run
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    t_lx_mode lx_mode       = LX_IDLE;
    t_cnt     lx_offset     = '0;
    t_cnt     lx_start      = '0;
    t_cnt     lx_len        = '0;
    logic     lx_space_seen = 1'b0;
    logic     lx_space_flag = 1'b0;
    t_token   lx_out[2];
    int       lx_n_out;

    t_token    expected_tokens[$];
    t_stim_row directed_rows[$];
    logic [7:0] text_bytes[$];

    int typed_n     = -1;
    t_token typed_tok[2];
    int errors      = 0;
    int tokens_seen = 0;
    int bytes_taken = 0;
    int texts_sent  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit tx_idle     = 1'b1;

    function automatic bit in_set(input string s, input logic [7:0] c);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] field16(input t_cnt v);
        longint unsigned w;
        w = longint'(v);
        return (w > 64'hFFFF) ? 16'hFFFF : 16'(w);
    endfunction

    function automatic t_token tok(input t_kind k, input logic sp, input int st,
                                   input int ln, input logic lst);
        t_token t;
        t.kind  = k;
        t.space = sp;
        t.start = 16'(st);
        t.len   = 16'(ln);
        t.last  = lst;
        return t;
    endfunction

    // Append one token to the queue of words the block still owes.
    task automatic queue_token(input t_token t);
        expected_tokens = {expected_tokens, t};
    endtask

    task automatic emit_token(input t_kind k);
        if (lx_n_out < 2) begin
            lx_out[lx_n_out] = tok(k, lx_space_flag, int'(field16(lx_start)),
                                   int'(field16(lx_len)), 1'b0);
            lx_n_out++;
        end
    endtask

    task automatic grow_token();
        if (lx_len != '1) lx_len++;
    endtask

    // Lex a byte in the idle state: spaces only mark the next token.
    task automatic open_token(input logic [7:0] ch);
        lx_mode = LX_IDLE;
        if (ch == CH_SPACE) begin
            lx_space_seen = 1'b1;
            return;
        end
        lx_space_flag = lx_space_seen;
        lx_space_seen = 1'b0;
        lx_start      = lx_offset;
        lx_len        = t_cnt'(1);
        if (ch == CH_LF) begin
            emit_token(KIND_LF);
        end else if (in_set(NUM_CHARS, ch)) begin
            lx_mode = LX_NUMBER;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            lx_mode = LX_SIGN;
        end else if (in_set(SYM_CHARS, ch)) begin
            emit_token(KIND_SYM);
        end else if (ch == CH_QUOTE) begin
            lx_mode = LX_QUOTED;
        end else begin
            lx_mode = LX_UNQUOTED;
        end
    endtask

    // Advance the predictor by one accepted byte; tokens land in lx_out.
    task automatic lex_byte(input logic [7:0] ch, input logic eot);
        lx_n_out = 0;
        case (lx_mode)
            LX_SIGN: begin
                if (in_set(NUM_CHARS, ch)) begin
                    lx_mode = LX_NUMBER;
                    grow_token();
                end else begin
                    emit_token(KIND_SYM);
                    open_token(ch);
                end
            end
            LX_NUMBER: begin
                if (in_set(NUM_CHARS, ch)) begin
                    grow_token();
                end else begin
                    emit_token(KIND_NUM);
                    open_token(ch);
                end
            end
            LX_UNQUOTED: begin
                if (in_set(END_CHARS, ch)) begin
                    emit_token(KIND_STR);
                    open_token(ch);
                end else begin
                    grow_token();
                end
            end
            LX_QUOTED: begin
                grow_token();
                if (ch == CH_QUOTE) begin
                    emit_token(KIND_STR);
                    lx_mode = LX_IDLE;
                end
            end
            default: begin
                open_token(ch);
            end
        endcase
        if (lx_offset != '1) lx_offset++;
        // The end of a text flushes whatever token is still open.
        if (eot) begin
            case (lx_mode) inside
                LX_SIGN:                 emit_token(KIND_SYM);
                LX_NUMBER:               emit_token(KIND_NUM);
                LX_UNQUOTED, LX_QUOTED:  emit_token(KIND_STR);
                default: ;
            endcase
            lx_mode       = LX_IDLE;
            lx_offset     = '0;
            lx_start      = '0;
            lx_len        = '0;
            lx_space_seen = 1'b0;
            lx_space_flag = 1'b0;
        end
        if (lx_n_out > 0) lx_out[lx_n_out-1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("[%0t] token %0d: %s expected 0x%0h, got 0x%0h",
                     $realtime, tokens_seen, what, want, got);
        end
    endtask

    // Both handshakes are sampled at the falling edge, where every signal is
    // settled; a word seen there is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_token want;
        logic   in_fire;
        logic   out_fire;
        if (i_rst_n) begin
            in_fire  = s_valid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && m_ready;
            if (in_fire) begin
                lex_byte(s_data, s_last);
                bytes_taken++;
                if (typed_n >= 0) begin
                    for (int i = 0; i < typed_n; i++) queue_token(typed_tok[i]);
                end else begin
                    for (int i = 0; i < lx_n_out; i++) queue_token(lx_out[i]);
                end
            end
            if (out_fire) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected word, tdata", 0, o_m_axis_tdata);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_m_axis_tuser != want.kind)
                        report_mismatch("kind", want.kind, o_m_axis_tuser);
                    if (o_m_axis_tdata[0] != want.space)
                        report_mismatch("space flag", want.space, o_m_axis_tdata[0]);
                    if (o_m_axis_tdata[16:1] != want.start)
                        report_mismatch("start offset", want.start, o_m_axis_tdata[16:1]);
                    if (o_m_axis_tdata[32:17] != want.len)
                        report_mismatch("length", want.len, o_m_axis_tdata[32:17]);
                    if (o_m_axis_tlast != want.last)
                        report_mismatch("last of run", want.last, o_m_axis_tlast);
                    if (o_m_axis_tdata[39:33] != '0)
                        report_mismatch("zero fill", 0, o_m_axis_tdata[39:33]);
                end
                tokens_seen++;
            end
            if (in_fire || out_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // The receiver stalls on a pattern that is redrawn each time it
    // wraps: sometimes no stall at all, sometimes sparse or dense stalls.
    logic [31:0] rx_pattern = '1;
    logic [4:0]  rx_step    = '0;

    always @(posedge i_clk) begin
        if (rx_step == 0) begin
            case ($urandom_range(0, 3))
                0:       rx_pattern = '1;
                1:       rx_pattern = $urandom;
                2:       rx_pattern = $urandom | $urandom;
                default: rx_pattern = ($urandom & $urandom) | 32'h1;
            endcase
        end
        m_ready <= rx_pattern[rx_step];
        rx_step  = rx_step + 1'b1;
    end

    // Drive one byte and return at the rising edge that takes it. The sender
    // works in bursts with random gaps between them while tx_idle is set.
    task automatic send_word(input logic [7:0] ch, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (tx_idle) begin
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 5);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= ch;
        s_last  <= eot;
        @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic eot, input int n,
                           input t_token a, input t_token b);
        t_stim_row r;
        r.ch      = ch;
        r.eot     = eot;
        r.n_typed = n;
        r.t0      = a;
        r.t1      = b;
        directed_rows = {directed_rows, r};
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // A byte that does not end an unquoted string, mostly a letter.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 70) begin
            c = CH_LOWER_A + 8'($urandom_range(0, 25));
        end else begin
            do c = 8'($urandom); while (in_set(END_CHARS, c));
        end
        return c;
    endfunction

    // Build one text: mostly well-formed tokens with random content, some
    // pure noise, and quoted strings that are sometimes left open.
    task automatic compose_text();
        int n_tok;
        int n;
        logic [7:0] b;
        text_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 8);
            repeat (n) text_bytes = {text_bytes, 8'($urandom)};
            return;
        end
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 2);
                repeat (n) text_bytes = {text_bytes, CH_SPACE};
            end
            case ($urandom_range(0, 6))
                0: begin
                    if ($urandom_range(0, 2) == 0) begin
                        b = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                        text_bytes = {text_bytes, b};
                    end
                    n = $urandom_range(1, 5);
                    repeat (n) text_bytes = {text_bytes, pick(NUM_CHARS)};
                end
                1: text_bytes = {text_bytes, pick(SYM_CHARS)};
                2: text_bytes = {text_bytes, CH_LF};
                3: begin
                    text_bytes = {text_bytes, CH_QUOTE};
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        b = ($urandom_range(0, 3) == 0) ?
                            8'($urandom | 1) & 8'hDF | 8'h01 : plain_byte();
                        text_bytes = {text_bytes, b};
                    end
                    if ($urandom_range(0, 99) < 85) text_bytes = {text_bytes, CH_QUOTE};
                end
                4, 5: begin
                    n = $urandom_range(1, 6);
                    repeat (n) text_bytes = {text_bytes, plain_byte()};
                end
                default: begin
                    b = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                    text_bytes = {text_bytes, b};
                end
            endcase
        end
    endtask

    initial begin
        t_token    nil;
        t_stim_row r;
        int        random_bytes;

        nil = tok(KIND_NUM, 1'b0, 0, 0, 1'b0);
        // Start of text, extremes of the byte, every token kind, tokens ended
        // by a byte that starts another, and open tokens flushed at the end.
        add_row(CH_LF,    1'b0, 1,  tok(KIND_LF, 1'b0, 0, 1, 1'b1), nil);
        add_row(CH_SPACE, 1'b0, 0,  nil, nil);
        add_row(CH_MINUS, 1'b0, -1, nil, nil);
        add_row(CH_MINUS, 1'b0, -1, nil, nil);
        add_row(CH_ZERO,  1'b0, -1, nil, nil);
        add_row(CH_DOT,   1'b0, -1, nil, nil);
        add_row(CH_NINE,  1'b0, -1, nil, nil);
        add_row(CH_QUOTE, 1'b0, -1, nil, nil);
        add_row(8'h00,    1'b0, -1, nil, nil);
        add_row(8'hFF,    1'b0, -1, nil, nil);
        add_row(CH_QUOTE, 1'b0, -1, nil, nil);
        add_row(8'h61,    1'b0, -1, nil, nil);
        add_row(8'h2C,    1'b0, -1, nil, nil);
        add_row(8'h3A,    1'b0, -1, nil, nil);
        add_row(8'h78,    1'b0, -1, nil, nil);
        add_row(8'h3A,    1'b0, -1, nil, nil);
        add_row(8'hFF,    1'b1, -1, nil, nil);
        add_row(CH_PLUS,  1'b1, 1,  tok(KIND_SYM, 1'b0, 0, 1, 1'b1), nil);
        add_row(CH_SPACE, 1'b1, 0,  nil, nil);
        add_row(CH_QUOTE, 1'b1, 1,  tok(KIND_STR, 1'b0, 0, 1, 1'b1), nil);
        add_row(8'h37,    1'b0, -1, nil, nil);
        add_row(CH_LF,    1'b1, -1, nil, nil);
        add_row(8'h71,    1'b0, -1, nil, nil);
        add_row(CH_QUOTE, 1'b1, -1, nil, nil);
        add_row(8'h80,    1'b1, 1,  tok(KIND_STR, 1'b0, 0, 1, 1'b1), nil);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            r            = directed_rows[i];
            typed_n      = r.n_typed;
            typed_tok[0] = r.t0;
            typed_tok[1] = r.t1;
            send_word(r.ch, r.eot);
        end
        typed_n = -1;
        texts_sent += 7;

        // Hold the sender until the block has delivered everything.
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            compose_text();
            tx_idle = ($urandom_range(0, 3) != 0);
            foreach (text_bytes[i]) begin
                send_word(text_bytes[i], i == text_bytes.size() - 1);
            end
            random_bytes += text_bytes.size();
            texts_sent++;
            if ($urandom_range(0, 19) == 0) begin
                s_valid <= 1'b0;
                while (expected_tokens.size() != 0) @(posedge i_clk);
            end
        end
        s_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d texts and %0d checked tokens,", bytes_taken,
                 texts_sent, tokens_seen);
        $display("with every token kind, end-of-text flushes and random stalls on both sides.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches.", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
